// ===== hw/rtl/hole_alloc_pkg.sv =====
// Shared types and constants of the first-fit / worst-fit hole allocator.
`timescale 1ns / 1ps
`default_nettype none
package hole_alloc_pkg;

  // Default table geometry
  localparam int MAX_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths
  localparam int IDX_W      = 4;
  localparam int SZ_W       = 16;
  localparam int FREE_W     = 20;
  localparam int HC_W       = 5;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Reset value of the hole count register
  localparam logic [HC_W-1:0] HOLE_COUNT_RST = HC_W'(16);

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_HALTED  = 2'd2,
    ST_LOADED  = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE   = 1'b0,
    REG_HOLE_COUNT = 1'b1
  } reg_idx_t;

  // Request item codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic            fit_mode;
    logic [HC_W-1:0] hole_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hole_alloc_mem.sv =====
// Hole size memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module hole_alloc_mem #(
  parameter int DEPTH = hole_alloc_pkg::MAX_HOLES_DEF,
  parameter int WIDTH = hole_alloc_pkg::SIZE_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] mem_q;
  logic             valid_q;

  // Write the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Mark written entries; reset empties the whole table
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    mem_q   <= mem[raddr];
    valid_q <= valid[raddr];
  end

  // Entries never written read as an empty hole
  assign rdata = valid_q ? mem_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/hole_alloc_ctrl.sv =====
// Sequencer of the hole allocator: scan, choice, write-back, free total and result register.
`timescale 1ns / 1ps
`default_nettype none
module hole_alloc_ctrl #(
  parameter int MAX_HOLES = hole_alloc_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hole_alloc_pkg::SIZE_BITS_DEF,
  localparam int AW = $clog2(MAX_HOLES)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hole_alloc_pkg::cfg_t                cfg,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                func,
  input  wire logic [hole_alloc_pkg::IDX_W-1:0]    hole_index,
  input  wire logic [hole_alloc_pkg::SZ_W-1:0]     size,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hole_alloc_pkg::STAT_W-1:0]        status,
  output logic [hole_alloc_pkg::IDX_W-1:0]         granted_hole,
  output logic [hole_alloc_pkg::SZ_W-1:0]          remaining,
  output logic [hole_alloc_pkg::FREE_W-1:0]        free_total,
  // memory port
  output logic                                     mem_we,
  output logic [AW-1:0]                            mem_waddr,
  output logic [SIZE_BITS-1:0]                     mem_wdata,
  output logic [AW-1:0]                            mem_raddr,
  input  wire logic [SIZE_BITS-1:0]                mem_rdata
);

  localparam int CW = $clog2(MAX_HOLES + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_LOAD_RD = 4'b0010,
    S_SCAN    = 4'b0100,
    S_FINISH  = 4'b1000
  } state_t;

  state_t                                state, state_next;
  logic [CW-1:0]                         cnt;
  logic [CW-1:0]                         n_use;
  logic                                  pend_v;
  logic [AW-1:0]                         pend_idx;
  logic                                  found;
  logic [SIZE_BITS-1:0]                  best;
  logic [SIZE_BITS-1:0]                  sz;
  logic [AW-1:0]                         wr_addr;
  hole_alloc_pkg::status_t               kind;
  logic                                  ld_ok;
  logic                                  halted;
  logic [hole_alloc_pkg::FREE_W-1:0]     free_sum;
  logic [hole_alloc_pkg::FREE_W-1:0]     free_next;

  logic                                  in_acc;
  logic                                  ld_in_range;
  logic                                  slot_free;
  logic                                  hit;
  logic                                  take;
  logic                                  last;
  logic                                  found_n;
  logic [SIZE_BITS-1:0]                  best_n;
  logic [AW-1:0]                         best_idx_n;
  logic [SIZE_BITS-1:0]                  rem;
  logic                                  is_granted;
  logic                                  finish_go;

  // Holes in use, clamped to the table depth
  always_comb begin
    if (32'(cfg.hole_count) > 32'(MAX_HOLES)) begin
      n_use = CW'(MAX_HOLES);
    end else begin
      n_use = CW'(cfg.hole_count);
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign ld_in_range = 32'(hole_index) < 32'(MAX_HOLES);
  assign slot_free   = !out_valid || out_ready;
  assign finish_go   = (state == S_FINISH) && slot_free;
  assign is_granted  = (kind == hole_alloc_pkg::ST_GRANTED);

  // Compare the returning entry against the running choice
  assign hit        = mem_rdata >= sz;
  assign take       = pend_v && hit && (!found || (cfg.fit_mode && (mem_rdata > best)));
  assign found_n    = found || take;
  assign best_n     = take ? mem_rdata : best;
  assign best_idx_n = take ? pend_idx : wr_addr;
  assign last       = pend_v && ((CW'(pend_idx) + CW'(1)) == n_use);
  assign rem        = best - sz;

  // Memory access: scan address while scanning, else the target entry
  assign mem_raddr = (state == S_SCAN) ? cnt[AW-1:0] : wr_addr;
  assign mem_waddr = wr_addr;
  assign mem_wdata = is_granted ? rem : sz;
  assign mem_we    = finish_go && (is_granted || ((kind == hole_alloc_pkg::ST_LOADED) && ld_ok));

  // Free total after this request
  always_comb begin
    free_next = free_sum;
    if ((kind == hole_alloc_pkg::ST_LOADED) && ld_ok) begin
      free_next = free_sum - hole_alloc_pkg::FREE_W'(mem_rdata)
                + hole_alloc_pkg::FREE_W'(sz);
    end else if (is_granted) begin
      free_next = free_sum - hole_alloc_pkg::FREE_W'(sz);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (func == hole_alloc_pkg::FUNC_LOAD) begin
            state_next = ld_in_range ? S_LOAD_RD : S_FINISH;
          end else if (halted || (n_use == '0)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_LOAD_RD: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      halted    <= 1'b0;
      free_sum  <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      state <= state_next;
      // issue tag for the read in flight
      if (state == S_SCAN) begin
        pend_v <= cnt < n_use;
      end else begin
        pend_v <= 1'b0;
      end
      // commit the request and publish its result
      if (finish_go) begin
        free_sum <= free_next;
        if (kind == hole_alloc_pkg::ST_LOADED) begin
          halted <= 1'b0;
        end else if ((kind == hole_alloc_pkg::ST_NOFIT) && cfg.fit_mode) begin
          halted <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          sz      <= SIZE_BITS'(size);
          wr_addr <= AW'(hole_index);
          ld_ok   <= ld_in_range;
          cnt     <= '0;
          found   <= 1'b0;
          if (func == hole_alloc_pkg::FUNC_LOAD) begin
            kind <= hole_alloc_pkg::ST_LOADED;
          end else if (halted) begin
            kind <= hole_alloc_pkg::ST_HALTED;
          end else begin
            kind <= hole_alloc_pkg::ST_NOFIT;
          end
        end
      end
      S_SCAN: begin
        if (cnt < n_use) begin
          cnt <= cnt + CW'(1);
        end
        pend_idx <= cnt[AW-1:0];
        found    <= found_n;
        best     <= best_n;
        wr_addr  <= best_idx_n;
        if (last) begin
          kind <= found_n ? hole_alloc_pkg::ST_GRANTED : hole_alloc_pkg::ST_NOFIT;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      status       <= kind;
      granted_hole <= is_granted ? hole_alloc_pkg::IDX_W'(wr_addr) : '0;
      remaining    <= is_granted ? hole_alloc_pkg::SZ_W'(rem) : '0;
      free_total   <= free_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/first_or_worst_fit_hole_allocator.sv =====
// Top level of the first-fit / worst-fit hole allocator: configuration registers and hookup.
//
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   fit_mode (index 0, bit 0: 0 first fit, 1 worst fit) and hole_count
//   (index 1, holes scanned from zero). cfg_ready is always high.
//   Request channel (in_valid/in_ready) carries func, hole_index, size.
//   func 0 loads one hole size, func 1 asks for an allocation.
//   Result channel (out_valid/out_ready) returns one result per request:
//   status, granted_hole, remaining and the total free space.
//   A load reads the old entry, then writes the new size and publishes its
//   result; a refused request goes straight to its result; an allocation
//   scans hole_count holes, clamped to MAX_HOLES, one hole read per cycle
//   from the memory, then writes back the chosen hole if one fits. Requests
//   are handled one at a time: a new one waits until the last result is registered.
//   The result sits in an output register; the next request is accepted while
//   it waits. If the receiver stalls, the following result holds the block.
//   Reset empties the hole table, clears the free total and the halt, and
//   sets first fit with 16 holes in use.
`timescale 1ns / 1ps
`default_nettype none
module first_or_worst_fit_hole_allocator #(
  parameter int MAX_HOLES = hole_alloc_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hole_alloc_pkg::SIZE_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // configuration
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [hole_alloc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hole_alloc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // requests
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic                                     func,
  input  wire logic [hole_alloc_pkg::IDX_W-1:0]         hole_index,
  input  wire logic [hole_alloc_pkg::SZ_W-1:0]          size,
  // results
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [hole_alloc_pkg::STAT_W-1:0]             status,
  output logic [hole_alloc_pkg::IDX_W-1:0]              granted_hole,
  output logic [hole_alloc_pkg::SZ_W-1:0]               remaining,
  output logic [hole_alloc_pkg::FREE_W-1:0]             free_total
);

  localparam int AW = $clog2(MAX_HOLES);

  hole_alloc_pkg::cfg_t   cfg;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SIZE_BITS-1:0]   mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [SIZE_BITS-1:0]   mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode   <= 1'b0;
      cfg.hole_count <= hole_alloc_pkg::HOLE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (hole_alloc_pkg::reg_idx_t'(cfg_index))
        hole_alloc_pkg::REG_FIT_MODE: begin
          cfg.fit_mode <= cfg_data[0];
        end
        hole_alloc_pkg::REG_HOLE_COUNT: begin
          cfg.hole_count <= hole_alloc_pkg::HC_W'(cfg_data);
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  hole_alloc_ctrl #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .hole_index   (hole_index),
    .size         (size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_hole (granted_hole),
    .remaining    (remaining),
    .free_total   (free_total),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  hole_alloc_mem #(
    .DEPTH (MAX_HOLES),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/hole_alloc_chk.sv =====
// Port-level checker of the hole allocator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hole_alloc_chk (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic [hole_alloc_pkg::STAT_W-1:0]     status,
  input wire logic [hole_alloc_pkg::IDX_W-1:0]      granted_hole,
  input wire logic [hole_alloc_pkg::SZ_W-1:0]       remaining,
  input wire logic [hole_alloc_pkg::FREE_W-1:0]     free_total
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_hole)
      && $stable(remaining) && $stable(free_total))
    else $error("result changed while stalled");

  // Only a grant names a hole or a remainder
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != hole_alloc_pkg::ST_GRANTED) |-> granted_hole == '0 && remaining == '0)
    else $error("non-granted result carries hole data");

  // One request at a time: acceptance drops ready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // A fresh result never appears in the cycle after acceptance of a request
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind first_or_worst_fit_hole_allocator hole_alloc_chk u_hole_alloc_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .granted_hole (granted_hole),
  .remaining    (remaining),
  .free_total   (free_total)
);
`default_nettype wire
